/* rtl/core/assert_macros.svh */
// Assertion macros shared by the core RTL.
// Each macro expands to one labeled concurrent assertion clocked by clk_i, reset by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MMDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define MMDU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/core/mmdu_pkg.sv */
// Package for the register-mapped multiply/divide unit.
// Holds register offsets, step counts and the unit status type; no dependencies.
`timescale 1ns / 1ps

package mmdu_pkg;

  localparam int unsigned OfsW     = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned MulSteps = 8;
  localparam int unsigned DivSteps = 16;

  // Register offsets within the 32-byte window.
  localparam logic [OfsW-1:0] OFS_MUL_A  = 5'h02;
  localparam logic [OfsW-1:0] OFS_MUL_B  = 5'h03;
  localparam logic [OfsW-1:0] OFS_DIV_LO = 5'h04;
  localparam logic [OfsW-1:0] OFS_DIV_HI = 5'h05;
  localparam logic [OfsW-1:0] OFS_DIV_B  = 5'h06;
  localparam logic [OfsW-1:0] OFS_QUO_LO = 5'h14;
  localparam logic [OfsW-1:0] OFS_QUO_HI = 5'h15;
  localparam logic [OfsW-1:0] OFS_RES_LO = 5'h16;
  localparam logic [OfsW-1:0] OFS_RES_HI = 5'h17;

  // Access kinds carried in tuser.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [WordW-1:0] DIV0_QUOT = 16'hFFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } mmdu_stat_t;

endpackage

/* rtl/core/mmdu_mul.sv */
// Serial 8x8 shift-add multiplier, one multiplier bit per cycle.
// Depends on mmdu_pkg.
`timescale 1ns / 1ps

module mmdu_mul import mmdu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ByteW-1:0] mcand_i,
  input  logic [ByteW-1:0] mplier_i,
  output mmdu_stat_t       stat_o,
  output logic [WordW-1:0] product_o
);

  localparam int unsigned CntW = $clog2(MulSteps);

  logic [ByteW-1:0] mcand_q;
  logic [WordW-1:0] acc_q, acc_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [ByteW:0]   sum;

  // Upper half accumulates, lower half shifts the multiplier bits out.
  always_comb begin
    sum   = {1'b0, acc_q[WordW-1:ByteW]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
    acc_d = {sum, acc_q[ByteW-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      acc_q   <= {{ByteW{1'b0}}, mplier_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MulSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign product_o   = acc_q;

endmodule

/* rtl/core/mmdu_div.sv */
// Serial restoring divider, 16-bit dividend by nonzero 8-bit divisor, one quotient bit per cycle.
// Depends on mmdu_pkg.
`timescale 1ns / 1ps

module mmdu_div import mmdu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [ByteW-1:0] divisor_i,
  output mmdu_stat_t       stat_o,
  output logic [WordW-1:0] quotient_o,
  output logic [ByteW-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(DivSteps);

  logic [ByteW-1:0] dsr_q, rem_q, rem_d;
  logic [WordW-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [ByteW:0]   trial;
  logic [ByteW+1:0] diff;
  logic             ge;

  // The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem_q, quo_q[WordW-1]};
    diff  = {1'b0, trial} - {2'b00, dsr_q};
    ge    = ~diff[ByteW+1];
    rem_d = ge ? diff[ByteW-1:0] : trial[ByteW-1:0];
    quo_d = {quo_q[WordW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

/* rtl/core/mmio_mul_div_unit_core.sv */
// Register-mapped 8x8 multiplier and 16/8 divider, top level.
// Depends on mmdu_pkg, mmdu_mul, mmdu_div and assert_macros.svh.
//
// Usage: each input item is one byte-wide register access. tuser carries the kind
// (read or write); tdata carries the offset, the write byte and the open-bus byte.
// Every item yields exactly one output item: the byte read, or zero for a write.
// Writing offset 3 starts a shift-add multiply; writing offset 6 with a
// nonzero divisor starts a restoring divide (one quotient bit per cycle).
// The response of the write is produced at once, but no further item is accepted
// until the unit has stored its results, after its last multiplier or quotient bit.
// All other accesses, including divide by zero, are done at once, so back-to-back
// reads stream at one item per cycle while the receiver does not stall.
// The response sits in an output register; while the receiver stalls with a
// response pending, tready stays low. Reset returns the operand registers to all
// ones and the results to zero, and leaves the output empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmio_mul_div_unit_core import mmdu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // reg_offset[4:0], write_data[12:5], open_bus_byte[20:13]
  input  logic        s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // read_data[7:0]
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [ByteW-1:0] mcand_q;
  logic [WordW-1:0] dividend_q, quotient_q, prodrem_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_data_q, rd_byte;

  logic [OfsW-1:0]  ofs;
  logic [ByteW-1:0] wdata, obus;
  logic             accept, is_wr;
  logic             mul_start, div_start, div_zero;

  mmdu_stat_t       mul_stat, div_stat;
  logic [WordW-1:0] mul_prod, div_quo;
  logic [ByteW-1:0] div_rem;

  assign ofs   = s_axis_tdata_i[4:0];
  assign wdata = s_axis_tdata_i[12:5];
  assign obus  = s_axis_tdata_i[20:13];
  assign is_wr = (s_axis_tuser_i == REQ_WRITE);

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign div_zero        = (wdata == '0);
  assign mul_start       = accept && is_wr && (ofs == OFS_MUL_B);
  assign div_start       = accept && is_wr && (ofs == OFS_DIV_B) && !div_zero;

  mmdu_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mcand_q),
    .mplier_i  (wdata),
    .stat_o    (mul_stat),
    .product_o (mul_prod)
  );

  mmdu_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dividend_q),
    .divisor_i   (wdata),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    unique case (ofs)
      OFS_QUO_LO: rd_byte = quotient_q[ByteW-1:0];
      OFS_QUO_HI: rd_byte = quotient_q[WordW-1:ByteW];
      OFS_RES_LO: rd_byte = prodrem_q[ByteW-1:0];
      OFS_RES_HI: rd_byte = prodrem_q[WordW-1:ByteW];
      default:    rd_byte = obus;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (mul_start) state_d = ST_MUL;
        else if (div_start) state_d = ST_DIV;
      end
      ST_MUL: if (mul_stat.done) state_d = ST_IDLE;
      ST_DIV: if (div_stat.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mcand_q     <= '1;
      dividend_q  <= '1;
      quotient_q  <= '0;
      prodrem_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept && is_wr) begin
        case (ofs)
          OFS_MUL_A:  mcand_q <= wdata;
          OFS_DIV_LO: dividend_q[ByteW-1:0] <= wdata;
          OFS_DIV_HI: dividend_q[WordW-1:ByteW] <= wdata;
          OFS_DIV_B: begin
            // A zero divisor bypasses the divider.
            if (div_zero) begin
              quotient_q <= DIV0_QUOT;
              prodrem_q  <= dividend_q;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_MUL && mul_stat.done) begin
        prodrem_q <= mul_prod;
      end
      if (state_q == ST_DIV && div_stat.done) begin
        quotient_q <= div_quo;
        prodrem_q  <= {{(WordW-ByteW){1'b0}}, div_rem};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= is_wr ? '0 : rd_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `MMDU_ASSERT(a_mul_done_in_mul, mul_stat.done |-> state_q == ST_MUL, "multiply done outside MUL")
  `MMDU_ASSERT(a_div_done_in_div, div_stat.done |-> state_q == ST_DIV, "divide done outside DIV")
  `MMDU_ASSERT(a_div_start_busy, div_start |=> div_stat.busy && !s_axis_tready_o,
               "divider not busy after start")
  `MMDU_ASSERT_NEVER(a_units_overlap, mul_stat.busy && div_stat.busy, "both units busy")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for mmio_mul_div_unit_core: register accesses go in, one byte per access comes out.
// A scoreboard class models the operand and result registers; depends on mmdu_pkg and the RTL.

module tb_top;
  import mmdu_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 40;
  localparam logic [OfsW-1:0] OFS_LOW_UNMAPPED = 5'h00;
  localparam logic [OfsW-1:0] OFS_TOP_UNMAPPED = 5'h1F;

  class mmdu_scoreboard;
    logic [ByteW-1:0] multiplicand;
    logic [ByteW-1:0] multiplier;
    logic [WordW-1:0] dividend;
    logic [ByteW-1:0] divisor;
    logic [WordW-1:0] quotient;
    logic [WordW-1:0] prod_rem;
    logic [ByteW-1:0] read_bytes_due[$];
    int unsigned      mismatches;

    function new();
      multiplicand = 8'hFF;
      multiplier   = 8'hFF;
      dividend     = 16'hFFFF;
      divisor      = 8'hFF;
      quotient     = '0;
      prod_rem     = '0;
      mismatches   = 0;
    endfunction

    // Updates the register model for one accepted access and queues the byte it returns.
    function void note_access(logic kind, logic [OfsW-1:0] ofs, logic [ByteW-1:0] wdata,
                              logic [ByteW-1:0] open_bus);
      logic [ByteW-1:0] rbyte;
      rbyte = '0;
      if (kind == REQ_WRITE) begin
        case (ofs)
          OFS_MUL_A: multiplicand = wdata;
          OFS_MUL_B: begin
            multiplier = wdata;
            prod_rem = {8'h00, multiplicand} * {8'h00, multiplier};
          end
          OFS_DIV_LO: dividend[7:0] = wdata;
          OFS_DIV_HI: dividend[15:8] = wdata;
          OFS_DIV_B: begin
            divisor = wdata;
            if (divisor != '0) begin
              quotient = dividend / {8'h00, divisor};
              prod_rem = dividend % {8'h00, divisor};
            end else begin
              quotient = DIV0_QUOT;
              prod_rem = dividend;
            end
          end
          default: ;
        endcase
      end else begin
        case (ofs)
          OFS_QUO_LO: rbyte = quotient[7:0];
          OFS_QUO_HI: rbyte = quotient[15:8];
          OFS_RES_LO: rbyte = prod_rem[7:0];
          OFS_RES_HI: rbyte = prod_rem[15:8];
          default:    rbyte = open_bus;
        endcase
      end
      read_bytes_due.push_back(rbyte);
    endfunction

    function void check_result(logic [ByteW-1:0] actual);
      logic [ByteW-1:0] due;
      if (read_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output item 0x%02h arrived with nothing outstanding", actual);
      end else begin
        due = read_bytes_due.pop_front();
        if (actual !== due) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: read_data expected 0x%02h, got 0x%02h", due, actual);
        end
      end
    endfunction

    function int unsigned pending();
      return read_bytes_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;

  mmdu_scoreboard sb = new();
  int unsigned    tx_idle_pct = 22;
  int unsigned    rx_idle_pct = 66;
  int unsigned    rx_hold_left = 0;
  int unsigned    cycle_count = 0;

  mmio_mul_div_unit_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one access, waits for it to be taken, then maybe leaves a gap.
  task automatic put_access(logic kind, logic [OfsW-1:0] ofs, logic [ByteW-1:0] wdata,
                            logic [ByteW-1:0] open_bus);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {3'b000, open_bus, wdata, ofs};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_access(kind, ofs, wdata, open_bus);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [OfsW-1:0] pick_result_ofs();
    case ($urandom_range(3))
      0:       return OFS_QUO_LO;
      1:       return OFS_QUO_HI;
      2:       return OFS_RES_LO;
      default: return OFS_RES_HI;
    endcase
  endfunction

  task automatic run_directed();
    // Results read straight after reset, then a divide by zero on the reset dividend.
    put_access(REQ_READ, OFS_QUO_LO, 8'h00, 8'hA5);
    put_access(REQ_READ, OFS_QUO_HI, 8'hFF, 8'h5A);
    put_access(REQ_READ, OFS_RES_LO, 8'h00, 8'hFF);
    put_access(REQ_READ, OFS_RES_HI, 8'h00, 8'h00);
    put_access(REQ_WRITE, OFS_DIV_B, 8'h00, 8'hFF);
    put_access(REQ_READ, OFS_QUO_LO, 8'h00, 8'h00);
    put_access(REQ_READ, OFS_QUO_HI, 8'h00, 8'h00);
    put_access(REQ_READ, OFS_RES_HI, 8'h00, 8'h00);
    // Largest product, then a zero multiplicand.
    put_access(REQ_WRITE, OFS_MUL_B, 8'hFF, 8'h00);
    put_access(REQ_READ, OFS_RES_LO, 8'h00, 8'h00);
    put_access(REQ_READ, OFS_RES_HI, 8'h00, 8'h00);
    put_access(REQ_WRITE, OFS_MUL_A, 8'h00, 8'h00);
    put_access(REQ_WRITE, OFS_MUL_B, 8'hFF, 8'h00);
    put_access(REQ_READ, OFS_RES_HI, 8'h00, 8'h00);
    // Largest dividend over one, then zero over the largest divisor.
    put_access(REQ_WRITE, OFS_DIV_B, 8'h01, 8'h00);
    put_access(REQ_READ, OFS_QUO_HI, 8'h00, 8'h00);
    put_access(REQ_WRITE, OFS_DIV_LO, 8'h00, 8'h00);
    put_access(REQ_WRITE, OFS_DIV_HI, 8'h00, 8'h00);
    put_access(REQ_WRITE, OFS_DIV_B, 8'hFF, 8'h00);
    put_access(REQ_READ, OFS_QUO_LO, 8'h00, 8'h00);
    // Writes to read-only and unmapped offsets are dropped; reads of unmapped and write-only offsets give the open bus.
    put_access(REQ_WRITE, OFS_QUO_LO, 8'hFF, 8'hFF);
    put_access(REQ_WRITE, OFS_TOP_UNMAPPED, 8'hFF, 8'hFF);
    put_access(REQ_READ, OFS_QUO_LO, 8'hFF, 8'hFF);
    put_access(REQ_READ, OFS_TOP_UNMAPPED, 8'h00, 8'hFF);
    put_access(REQ_READ, OFS_LOW_UNMAPPED, 8'hFF, 8'h00);
    put_access(REQ_READ, OFS_MUL_A, 8'h00, 8'h5A);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          put_access(REQ_WRITE, OFS_MUL_A, pick_byte(), pick_byte());
          put_access(REQ_WRITE, OFS_MUL_B, pick_byte(), pick_byte());
          put_access(REQ_READ, OFS_RES_LO, pick_byte(), pick_byte());
          put_access(REQ_READ, OFS_RES_HI, pick_byte(), pick_byte());
          sent += 4;
        end
        3, 4, 5: begin
          // Now and then one or both dividend bytes are left as they were.
          if ($urandom_range(4) != 0) begin
            put_access(REQ_WRITE, OFS_DIV_LO, pick_byte(), pick_byte());
            sent++;
          end
          if ($urandom_range(4) != 0) begin
            put_access(REQ_WRITE, OFS_DIV_HI, pick_byte(), pick_byte());
            sent++;
          end
          put_access(REQ_WRITE, OFS_DIV_B, ($urandom_range(7) == 0) ? 8'h00 : pick_byte(),
                     pick_byte());
          put_access(REQ_READ, OFS_QUO_LO, pick_byte(), pick_byte());
          put_access(REQ_READ, OFS_QUO_HI, pick_byte(), pick_byte());
          put_access(REQ_READ, OFS_RES_LO, pick_byte(), pick_byte());
          put_access(REQ_READ, OFS_RES_HI, pick_byte(), pick_byte());
          sent += 5;
        end
        6, 7: begin
          put_access(logic'($urandom_range(1)), OfsW'($urandom_range(31)), pick_byte(),
                     pick_byte());
          sent++;
        end
        8: begin
          // Broken sequence: a lone operand or start write, then a result read.
          put_access(REQ_WRITE, OfsW'($urandom_range(OFS_MUL_A, OFS_DIV_B)), pick_byte(),
                     pick_byte());
          put_access(REQ_READ, pick_result_ofs(), pick_byte(), pick_byte());
          sent += 2;
        end
        default: begin
          put_access(REQ_READ, pick_result_ofs(), pick_byte(), pick_byte());
          sent++;
        end
      endcase
    end
  endtask

  // Output side: checks each taken item and stalls at random or for a requested stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("mmio_mul_div_unit_core test failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(233);
    wait_drained();
    repeat ($urandom_range(1, 20)) @(posedge clk_i);

    tx_idle_pct = 66;
    rx_idle_pct = 22;
    run_random(233);

    // The output stalls for a long stretch while items keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_left = 400;
    run_random(234);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("mmio_mul_div_unit_core test passed");
    end else begin
      $display("mmio_mul_div_unit_core test failed");
    end
    $finish;
  end

endmodule
